// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// ----- src/mspc_pkg.sv -----
package mspc_pkg;

	// Event kinds
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_PULSE  = 2'd1;
	localparam logic [1:0] OP_BUTTON = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_MAX_MODE      = 3'd0;
	localparam logic [2:0] REG_HOLD_TICKS    = 3'd1;
	localparam logic [2:0] REG_BASE_WIDTH_US = 3'd2;
	localparam logic [2:0] REG_STEP_WIDTH_US = 3'd3;
	localparam logic [2:0] REG_RPM_PER_PULSE = 3'd4;

	// Register reset values
	localparam logic [6:0]  RST_MAX_MODE      = 7'd127;
	localparam logic [7:0]  RST_HOLD_TICKS    = 8'd10;
	localparam logic [14:0] RST_BASE_WIDTH_US = 15'd1000;
	localparam logic [9:0]  RST_STEP_WIDTH_US = 10'd100;
	localparam logic [15:0] RST_RPM_PER_PULSE = 16'd600;

	localparam logic [13:0] SHOW_MAX     = 14'd9999;
	localparam logic [15:0] PULSE_MAX    = 16'hFFFF;
	localparam logic [15:0] DIV10_MUL    = 16'd52429;   // 2^19/10 rounded up
	localparam int          DIV10_SHIFT  = 19;

	typedef struct packed {
		logic [1:0] opcode;
		logic       up_button_low;
		logic       down_button_low;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  seg_thousands;
		logic [6:0]  seg_hundreds;
		logic [6:0]  seg_tens;
		logic [6:0]  seg_ones;
		logic        showing_mode;
		logic [15:0] pwm_compare;
	} result_t;

	typedef struct packed {
		logic        up;
		logic        down;
		logic        pending;
		logic [15:0] pulses;
	} tick_cmd_t;

	typedef struct packed {
		logic [6:0]  max_mode;
		logic [7:0]  hold_ticks;
		logic [14:0] base_width_us;
		logic [9:0]  step_width_us;
		logic [15:0] rpm_per_pulse;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PWM,
		ST_SCALE,
		ST_DIGIT,
		ST_EMIT
	} back_state_t;

	function automatic logic [6:0] seg_code(input logic [3:0] digit);
		logic [6:0] code;
		case (digit)
			4'd0: code = 7'h3F;
			4'd1: code = 7'h06;
			4'd2: code = 7'h5B;
			4'd3: code = 7'h4F;
			4'd4: code = 7'h66;
			4'd5: code = 7'h6D;
			4'd6: code = 7'h7D;
			4'd7: code = 7'h07;
			4'd8: code = 7'h7F;
			4'd9: code = 7'h6F;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

endpackage

// ----- src/mspc_fifo.sv -----
`include "assert_macros.svh"

module mspc_fifo #(
	parameter int DEPTH = 2,   // 2 or more
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wr_data,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rd_data,
	output logic          empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(DEPTH), "fifo count over depth")
	`ASSERT_IMPL(a_count_up, clk, arst_n, (do_push && !do_pop) |=> count_q == $past(count_q) + CW'(1), "fifo count missed a push")
	`ASSERT_IMPL(a_count_down, clk, arst_n, (do_pop && !do_push) |=> count_q == $past(count_q) - CW'(1), "fifo count missed a pop")

endmodule

// ----- src/mspc_front.sv -----
module mspc_front
	import mspc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  item,
	output logic      full,
	output logic      cmd_push,
	output tick_cmd_t cmd,
	input  logic      cmd_full
);

	logic [15:0] pulse_count_q;
	logic        pending_q;
	logic        accept;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// A tick snapshots the pulse count and the pending flag.
	assign cmd_push    = accept && (item.opcode == OP_TICK);
	assign cmd.up      = item.up_button_low;
	assign cmd.down    = item.down_button_low;
	assign cmd.pending = pending_q;
	assign cmd.pulses  = pulse_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_count_q <= '0;
			pending_q     <= 1'b0;
		end else if (accept) begin
			case (item.opcode)
				OP_TICK: begin
					pulse_count_q <= '0;
					pending_q     <= 1'b0;
				end
				OP_PULSE: begin
					if (pulse_count_q != PULSE_MAX) begin
						pulse_count_q <= pulse_count_q + 16'd1;
					end
				end
				OP_BUTTON: begin
					pending_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- src/mspc_back.sv -----
`include "assert_macros.svh"

module mspc_back
	import mspc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  tick_cmd_t cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	output result_t   res,
	input  logic      res_full,
	output logic      res_push
);

	back_state_t state_q, state_d;

	// Persistent state
	logic [6:0]  mode_q, prev_q;
	logic [7:0]  hold_q;
	logic [15:0] rpm_q;

	// Per-tick working registers
	logic [13:0] shown_q;
	logic        showing_q;
	logic [15:0] pulses_q;
	logic [17:0] width_q;
	logic [15:0] pwm_q;
	logic [13:0] val_q;
	logic [1:0]  dcnt_q;
	logic [3:0]  dig_q [3];

	// Mode update and display choice
	logic [7:0]  m_raw;
	logic [6:0]  new_mode;
	logic [7:0]  hold_base;
	logic        show_mode;
	logic [13:0] shown_d;

	always_comb begin
		m_raw = {1'b0, mode_q};
		if (cmd.pending) begin
			if (cmd.up && !cmd.down) begin
				m_raw = {1'b0, mode_q} + 8'd1;
			end else if (cmd.down && !cmd.up && mode_q != 7'd0) begin
				m_raw = {1'b0, mode_q} - 8'd1;
			end
			if (m_raw > {1'b0, cfg.max_mode}) begin
				m_raw = {1'b0, cfg.max_mode};
			end
		end
		new_mode  = m_raw[6:0];
		hold_base = (new_mode != prev_q) ? 8'd0 : hold_q;
		show_mode = (hold_base < cfg.hold_ticks);
		if (show_mode) begin
			shown_d = {7'd0, new_mode};
		end else if (rpm_q > {2'b00, SHOW_MAX}) begin
			shown_d = SHOW_MAX;
		end else begin
			shown_d = rpm_q[13:0];
		end
	end

	// Arithmetic
	logic [20:0] width_x5;
	logic [31:0] rpm_prod;
	logic [29:0] div_prod;
	logic [13:0] quot;
	logic [13:0] digit;

	assign width_x5 = {1'b0, width_q, 2'b00} + 21'(width_q);
	assign rpm_prod = 32'(pulses_q) * 32'(cfg.rpm_per_pulse);
	assign div_prod = 30'(val_q) * 30'(DIV10_MUL);
	assign quot     = 14'(div_prod >> DIV10_SHIFT);
	assign digit    = val_q - ((quot << 3) + (quot << 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (!cmd_empty) state_d = ST_PWM;
			ST_PWM:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_DIGIT;
			ST_DIGIT: if (dcnt_q == 2'd2) state_d = ST_EMIT;
			ST_EMIT:  if (!res_full) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		case (state_q)
			ST_IDLE: cmd_pop  = !cmd_empty;
			ST_EMIT: res_push = !res_full;
			default: begin
			end
		endcase
	end

	assign res.seg_thousands = seg_code(val_q[3:0]);
	assign res.seg_hundreds  = seg_code(dig_q[2]);
	assign res.seg_tens      = seg_code(dig_q[1]);
	assign res.seg_ones      = seg_code(dig_q[0]);
	assign res.showing_mode  = showing_q;
	assign res.pwm_compare   = pwm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= '0;
			prev_q  <= '0;
			hold_q  <= '0;
			rpm_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				mode_q <= new_mode;
				prev_q <= new_mode;
				hold_q <= show_mode ? hold_base + 8'd1 : hold_base;
			end
			if (state_q == ST_SCALE) begin
				rpm_q <= (rpm_prod[31:16] != 16'd0) ? 16'hFFFF : rpm_prod[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				shown_q   <= shown_d;
				showing_q <= show_mode;
				pulses_q  <= cmd.pulses;
			end
			ST_PWM: begin
				width_q <= 18'(cfg.base_width_us) + 18'(mode_q) * 18'(cfg.step_width_us);
			end
			ST_SCALE: begin
				// width * 625 / 1000 == width * 5 / 8
				pwm_q  <= (width_x5[20:19] != 2'd0) ? 16'hFFFF : width_x5[18:3];
				val_q  <= shown_q;
				dcnt_q <= 2'd0;
			end
			ST_DIGIT: begin
				dig_q[dcnt_q] <= digit[3:0];
				val_q         <= quot;
				dcnt_q        <= dcnt_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	`ASSERT_NEVER(a_digit_range, clk, arst_n, state_q == ST_DIGIT && digit > 14'd9, "digit step left a remainder of ten or more")
	`ASSERT_IMPL(a_pop_advances, clk, arst_n, (state_q == ST_IDLE && !cmd_empty) |=> state_q == ST_PWM, "popped tick not processed")
	`ASSERT_NEVER(a_shown_mode, clk, arst_n, state_q != ST_IDLE && showing_q && shown_q != {7'd0, mode_q}, "mode display does not match mode")

endmodule

// ----- src/motor_speed_panel_controller_unit.sv -----
// Path: an accepted tick transaction passes through the tick queue and the
// back-end sequencer before it shows up as a result in the result queue.
// Throughput: pulse and button transactions every cycle while the tick queue has
// room; the back end takes one tick at a time (mode, PWM multiply, rpm scale,
// three divide-by-ten digit steps, emit); it stalls in emit while results wait.
// Reset (arst_n low, asynchronous): control state zero, registers at their defaults.
module motor_speed_panel_controller_unit
	import mspc_pkg::*;
#(
	parameter int CMD_DEPTH = 2,   // tick queue depth, 2 or more
	parameter int RES_DEPTH = 2    // result queue depth, 2 or more
) (
	input  logic        clk,
	input  logic        arst_n,
	// input side
	input  logic        push,
	input  in_item_t    item,
	output logic        full,
	// result side
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers. Writes are to arrive only while the block is idle;
	// the block does not enforce this. Hold them here and feed the back end directly.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_mode      <= RST_MAX_MODE;
			cfg_q.hold_ticks    <= RST_HOLD_TICKS;
			cfg_q.base_width_us <= RST_BASE_WIDTH_US;
			cfg_q.step_width_us <= RST_STEP_WIDTH_US;
			cfg_q.rpm_per_pulse <= RST_RPM_PER_PULSE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_MODE:      cfg_q.max_mode      <= cfg_data[6:0];
				REG_HOLD_TICKS:    cfg_q.hold_ticks    <= cfg_data[7:0];
				REG_BASE_WIDTH_US: cfg_q.base_width_us <= cfg_data[14:0];
				REG_STEP_WIDTH_US: cfg_q.step_width_us <= cfg_data[9:0];
				REG_RPM_PER_PULSE: cfg_q.rpm_per_pulse <= cfg_data;
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// Front end: count pulses and latch button edges as they arrive; on a
	// tick, push a snapshot (buttons, pending flag, pulse count) into the
	// tick queue and clear the counters. Pulses after the tick count toward
	// the next one, so the front waits on the back only when the tick queue
	// is full.
	logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
	tick_cmd_t cmd_wr, cmd_rd;

	mspc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_wr),
		.cmd_full (cmd_full)
	);

	// Tick queue: decouple event intake from tick processing.
	mspc_fifo #(
		.DEPTH (CMD_DEPTH),
		.DW    ($bits(tick_cmd_t))
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	// Back end: step the mode, pick the display value, compute the PWM
	// compare and the next rpm, split the value into digits.
	logic    res_push, res_full;
	result_t res_wr;

	mspc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd_rd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res_wr),
		.res_full  (res_full),
		.res_push  (res_push)
	);

	// Result queue: hold finished results until the consumer pops them,
	// letting the back end move on to the next tick.
	mspc_fifo #(
		.DEPTH (RES_DEPTH),
		.DW    ($bits(result_t))
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.pop     (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
